// ===== rtl/shce_pkg.sv =====
// Shared types and constants of the stick HSV colour editor.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package shce_pkg;

  localparam int unsigned STEP_W = 4;
  localparam int unsigned APB_AW = 3;

  localparam logic [14:0] DEAD_ZONE_RST = 15'd8000;
  localparam logic        REG_DEAD_ZONE = 1'b0;

  typedef enum logic [3:0] {
    OP_SAT_MUL,
    OP_SAT_UPD,
    OP_VAL_UPD,
    OP_SETUP,
    OP_SR_MUL,
    OP_X_SUB,
    OP_LO_MUL,
    OP_HI_MUL,
    OP_SUM,
    OP_DIV_MUL,
    OP_STORE,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic run;
    logic capture;
    op_e  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic k_last;
    logic out_free;
  } seq_status_t;

endpackage

// ===== rtl/stick_hsv_color_editor_unit.sv =====
// Stick HSV colour editor: takes one stick sample per request, steps the hue,
// saturation and value, and returns the colour as 24-bit RGB with its palette
// slot. The block accepts a request and stalls its input while the microprogram
// runs, taking no new request before it is through; the last step waits while a
// stalled result holds the output register. The microprogram has four steps that
// update the colour state and prepare the conversion, seven steps for each of the
// four components v, p, q and t, and one that hands over the result. The single
// shared 24 by 19 bit multiplier is used eighteen times per request, twice for the
// saturation and value steps and four times for each component. A finished colour
// waits in an output register, so the next request can be taken while it is still
// held. The dead zone register sits at byte address 0 of the APB port. Depends on
// shce_pkg, shce_sequencer and shce_datapath.
module stick_hsv_color_editor_unit
  import shce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] hue_stick_i,
  input  logic signed [15:0] sat_stick_i,
  input  logic signed [15:0] val_stick_i,
  input  logic [7:0]         global_level_i,
  input  logic [1:0]         slot_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        rgb_color_o,
  output logic [1:0]         slot_out_o
);

  logic [14:0] dead_zone_q;
  logic        out_valid_q, out_valid_d;
  logic [23:0] rgb_q;
  logic [1:0]  slot_q;

  dp_ctrl_t    dp_ctrl;
  seq_status_t seq_status;
  logic        seq_busy;
  logic        seq_done;
  logic        k_last;
  logic [23:0] dp_rgb;
  logic [1:0]  dp_slot;
  logic        cfg_wr;
  logic        in_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {17'd0, dead_zone_q} : '0;

  assign in_stall_o = seq_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign seq_status.k_last   = k_last;
  assign seq_status.out_free = !out_valid_q || !out_stall_i;

  shce_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_valid_i),
    .status_i (seq_status),
    .ctrl_o   (dp_ctrl),
    .busy_o   (seq_busy),
    .done_o   (seq_done)
  );

  shce_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (dp_ctrl),
    .dead_zone_i    (dead_zone_q),
    .hue_stick_i    (hue_stick_i),
    .sat_stick_i    (sat_stick_i),
    .val_stick_i    (val_stick_i),
    .global_level_i (global_level_i),
    .slot_in_i      (slot_in_i),
    .rgb_o          (dp_rgb),
    .slot_o         (dp_slot),
    .k_last_o       (k_last)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= DEAD_ZONE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_DEAD_ZONE)) begin
        dead_zone_q <= pwdata[14:0];
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      rgb_q  <= dp_rgb;
      slot_q <= dp_slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rgb_color_o = rgb_q;
  assign slot_out_o  = slot_q;

`ifndef SYNTHESIS
  a_busy_after_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("Sequencer did not start on an accepted request.");

  a_valid_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(seq_done))
    else $error("Result appeared without the microprogram finishing.");

  a_done_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> (!out_valid_q || !out_stall_i))
    else $error("Microprogram finished onto a held result.");
`endif

endmodule

// ===== rtl/shce_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on shce_pkg for the control word and status types.
module shce_sequencer
  import shce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  seq_status_t status_i,
  output dp_ctrl_t    ctrl_o,
  output logic        busy_o,
  output logic        done_o
);

  localparam logic [STEP_W-1:0] STEP_COMP_LOOP = 4'd4;

  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_FINISH, jump: 1'b0, target: '0};
    case (step)
      4'd0:    w.op = OP_SAT_MUL;
      4'd1:    w.op = OP_SAT_UPD;
      4'd2:    w.op = OP_VAL_UPD;
      4'd3:    w.op = OP_SETUP;
      4'd4:    w.op = OP_SR_MUL;
      4'd5:    w.op = OP_X_SUB;
      4'd6:    w.op = OP_LO_MUL;
      4'd7:    w.op = OP_HI_MUL;
      4'd8:    w.op = OP_SUM;
      4'd9:    w.op = OP_DIV_MUL;
      4'd10:   w = '{op: OP_STORE, jump: 1'b1, target: STEP_COMP_LOOP};
      default: w.op = OP_FINISH;
    endcase
    return w;
  endfunction

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;

  assign word = ucode_word(step_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (word.op == OP_FINISH) begin
      if (status_i.out_free) begin
        busy_d = 1'b0;
        step_d = '0;
      end
    end else if (word.jump && !status_i.k_last) begin
      step_d = word.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    ctrl_o.run     = busy_q;
    ctrl_o.capture = start_i && !busy_q;
    ctrl_o.op      = word.op;
    busy_o         = busy_q;
    done_o         = busy_q && (word.op == OP_FINISH) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/shce_datapath.sv =====
// Datapath of the colour editor: HSV accumulators, one shared multiplier and the
// HSV to RGB conversion registers. Depends on shce_pkg for the control types.
module shce_datapath
  import shce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_ctrl_t           ctrl_i,
  input  logic [14:0]        dead_zone_i,
  input  logic signed [15:0] hue_stick_i,
  input  logic signed [15:0] sat_stick_i,
  input  logic signed [15:0] val_stick_i,
  input  logic [7:0]         global_level_i,
  input  logic [1:0]         slot_in_i,
  output logic [23:0]        rgb_o,
  output logic [1:0]         slot_o,
  output logic               k_last_o
);

  localparam logic signed [23:0] HUE_FULL = 24'sd2949120;
  localparam logic [18:0]        SECTOR   = 19'd491520;
  localparam logic [34:0]        WHOLE    = 35'd32212254720;
  localparam logic [18:0]        K_STEP   = 19'd5243;
  localparam logic [18:0]        K_DIV15  = 19'd8739;
  localparam logic [21:0]        HUE_RST  = 22'd983040;
  localparam logic [16:0]        SAT_RST  = 17'd65536;
  localparam logic [16:0]        VAL_RST  = 17'd32896;
  localparam logic [1:0]         COMP_V   = 2'd0;
  localparam logic [1:0]         COMP_P   = 2'd1;
  localparam logic [1:0]         COMP_Q   = 2'd2;
  localparam logic [1:0]         COMP_T   = 2'd3;

  function automatic logic [15:0] magnitude(input logic [15:0] x);
    return x[15] ? (~x + 16'd1) : x;
  endfunction

  function automatic logic [16:0] nudge(input logic [16:0] acc, input logic [27:0] prodv,
                                        input logic dec);
    logic [27:0]        rounded;
    logic [11:0]        step;
    logic signed [18:0] r;
    rounded = prodv + 28'd32768;
    step    = rounded[27:16];
    if (dec) begin
      r = $signed({2'b00, acc}) - $signed({7'd0, step});
    end else begin
      r = $signed({2'b00, acc}) + $signed({7'd0, step});
    end
    if (r < 0) begin
      return '0;
    end else if (r > 19'sd65536) begin
      return 17'd65536;
    end
    return r[16:0];
  endfunction

  // Captured request.
  logic signed [15:0] hs_q, ss_q, vs_q;
  logic [7:0]         level_q;
  logic [1:0]         slot_q;

  // Colour state.
  logic [21:0] hue_q, hue_d;
  logic [16:0] sat_q, sat_d;
  logic [16:0] val_q, val_d;
  logic [1:0]  k_q, k_d;

  // Conversion working registers.
  logic [42:0] prod_q, prod_d;
  logic [23:0] v255_q, v255_d;
  logic [2:0]  sector_q, sector_d;
  logic [18:0] rem_q, rem_d;
  logic [34:0] x_q, x_d;
  logic [41:0] lo_q, lo_d;
  logic [11:0] y_q, y_d;
  logic [7:0]  comp_q [4];
  logic [7:0]  comp_d [4];

  logic [15:0]        hue_mag, sat_mag, val_mag;
  logic               hue_act, sat_act, val_act;
  logic signed [23:0] hue_sum, hue_wrap;
  logic [23:0]        mul_a;
  logic [18:0]        mul_b;
  logic [42:0]        mul_p;
  logic [18:0]        r_sel;
  logic [58:0]        sum_w;
  logic [8:0]         quot;
  logic [21:0]        sec_base;
  logic [2:0]         sec_num;
  logic [7:0]         red, green, blue;

  assign hue_mag = magnitude(hs_q);
  assign sat_mag = magnitude(ss_q);
  assign val_mag = magnitude(vs_q);
  assign hue_act = hue_mag > {1'b0, dead_zone_i};
  assign sat_act = sat_mag > {1'b0, dead_zone_i};
  assign val_act = val_mag > {1'b0, dead_zone_i};

  always_comb begin
    hue_sum  = $signed({2'b00, hue_q}) + 24'(hs_q);
    hue_wrap = hue_sum;
    if (hue_sum < 0) begin
      hue_wrap = hue_sum + HUE_FULL;
    end else if (hue_sum >= HUE_FULL) begin
      hue_wrap = hue_sum - HUE_FULL;
    end
  end

  always_comb begin
    if (hue_q >= 22'(5 * SECTOR)) begin
      sec_num  = 3'd5;
      sec_base = 22'(5 * SECTOR);
    end else if (hue_q >= 22'(4 * SECTOR)) begin
      sec_num  = 3'd4;
      sec_base = 22'(4 * SECTOR);
    end else if (hue_q >= 22'(3 * SECTOR)) begin
      sec_num  = 3'd3;
      sec_base = 22'(3 * SECTOR);
    end else if (hue_q >= 22'(2 * SECTOR)) begin
      sec_num  = 3'd2;
      sec_base = 22'(2 * SECTOR);
    end else if (hue_q >= 22'(SECTOR)) begin
      sec_num  = 3'd1;
      sec_base = 22'(SECTOR);
    end else begin
      sec_num  = 3'd0;
      sec_base = '0;
    end
  end

  always_comb begin
    case (k_q)
      COMP_V:  r_sel = '0;
      COMP_P:  r_sel = SECTOR;
      COMP_Q:  r_sel = rem_q;
      default: r_sel = SECTOR - rem_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.op)
      OP_SAT_MUL: begin
        mul_a = 24'(sat_mag);
        mul_b = K_STEP;
      end
      OP_SAT_UPD: begin
        mul_a = 24'(val_mag);
        mul_b = K_STEP;
      end
      OP_SR_MUL: begin
        mul_a = 24'(sat_q);
        mul_b = r_sel;
      end
      OP_LO_MUL: begin
        mul_a = v255_q;
        mul_b = 19'(x_q[17:0]);
      end
      OP_HI_MUL: begin
        mul_a = v255_q;
        mul_b = 19'(x_q[34:18]);
      end
      OP_DIV_MUL: begin
        mul_a = 24'(y_q);
        mul_b = K_DIV15;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {19'd0, mul_a} * {24'd0, mul_b};
  assign sum_w = {prod_q[40:0], 18'd0} + {17'd0, lo_q};
  assign quot  = prod_q[25:17];

  always_comb begin
    hue_d    = hue_q;
    sat_d    = sat_q;
    val_d    = val_q;
    k_d      = k_q;
    prod_d   = prod_q;
    v255_d   = v255_q;
    sector_d = sector_q;
    rem_d    = rem_q;
    x_d      = x_q;
    lo_d     = lo_q;
    y_d      = y_q;
    comp_d   = comp_q;
    if (ctrl_i.run) begin
      case (ctrl_i.op)
        OP_SAT_MUL: begin
          prod_d = mul_p;
          if (hue_act) begin
            hue_d = hue_wrap[21:0];
          end
        end
        OP_SAT_UPD: begin
          prod_d = mul_p;
          if (sat_act) begin
            sat_d = nudge(sat_q, prod_q[27:0], !ss_q[15]);
          end
        end
        OP_VAL_UPD: begin
          if (val_act) begin
            val_d = nudge(val_q, prod_q[27:0], !vs_q[15]);
          end else begin
            val_d = {1'b0, level_q, level_q};
          end
        end
        OP_SETUP: begin
          v255_d   = 24'(({8'd0, val_q} << 8) - {8'd0, val_q});
          sector_d = sec_num;
          rem_d    = 19'(hue_q - sec_base);
          k_d      = '0;
        end
        OP_SR_MUL:  prod_d = mul_p;
        OP_X_SUB:   x_d = WHOLE - prod_q[34:0];
        OP_LO_MUL:  prod_d = mul_p;
        OP_HI_MUL: begin
          lo_d   = prod_q[41:0];
          prod_d = mul_p;
        end
        OP_SUM:     y_d = sum_w[58:47];
        OP_DIV_MUL: prod_d = mul_p;
        OP_STORE: begin
          comp_d[k_q] = quot[8] ? 8'hFF : quot[7:0];
          k_d         = k_q + 2'd1;
        end
        default: begin
          k_d = k_q;
        end
      endcase
    end
  end

  always_comb begin
    case (sector_q)
      3'd0: begin
        red = comp_q[COMP_V]; green = comp_q[COMP_T]; blue = comp_q[COMP_P];
      end
      3'd1: begin
        red = comp_q[COMP_Q]; green = comp_q[COMP_V]; blue = comp_q[COMP_P];
      end
      3'd2: begin
        red = comp_q[COMP_P]; green = comp_q[COMP_V]; blue = comp_q[COMP_T];
      end
      3'd3: begin
        red = comp_q[COMP_P]; green = comp_q[COMP_Q]; blue = comp_q[COMP_V];
      end
      3'd4: begin
        red = comp_q[COMP_T]; green = comp_q[COMP_P]; blue = comp_q[COMP_V];
      end
      default: begin
        red = comp_q[COMP_V]; green = comp_q[COMP_P]; blue = comp_q[COMP_Q];
      end
    endcase
  end

  assign rgb_o    = {red, green, blue};
  assign slot_o   = slot_q;
  assign k_last_o = (k_q == COMP_T);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= HUE_RST;
      sat_q <= SAT_RST;
      val_q <= VAL_RST;
      k_q   <= '0;
    end else begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      hs_q    <= hue_stick_i;
      ss_q    <= sat_stick_i;
      vs_q    <= val_stick_i;
      level_q <= global_level_i;
      slot_q  <= slot_in_i;
    end
    prod_q   <= prod_d;
    v255_q   <= v255_d;
    sector_q <= sector_d;
    rem_q    <= rem_d;
    x_q      <= x_d;
    lo_q     <= lo_d;
    y_q      <= y_d;
    comp_q   <= comp_d;
  end

endmodule
